// ===== design/ts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_pkg
// Types and constants shared by the texture sampler modules.
// ----------------------------------------------------------------------------
package ts_pkg;

    // Action codes of an incoming request
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_TEX_WIDTH  = 1'b0;
    localparam logic CFG_TEX_HEIGHT = 1'b1;

    // Filter modes; the unused code samples as bilinear
    localparam logic [1:0] MODE_WRAP     = 2'd0;
    localparam logic [1:0] MODE_CLAMP    = 2'd1;
    localparam logic [1:0] MODE_BILINEAR = 2'd2;

    localparam int          CFG_W      = 9;
    localparam int          TEXEL_W    = 24;
    localparam int          WT_W       = 17;
    localparam logic [22:0] Q_ONE      = 23'h010000;
    localparam logic [WT_W-1:0] WEIGHT_ONE = 17'h10000;
    localparam logic [23:0] ROUND_HALF = 24'h008000;

    // Texel reads of one bilinear sample
    localparam int TAPS  = 4;
    localparam int TAP_W = 2;

    // Result buffer depth
    localparam int OUT_DEPTH = 4;

    typedef struct packed {
        logic              action;
        logic [7:0]        texel_x;
        logic [7:0]        texel_y;
        logic [7:0]        texel_red;
        logic [7:0]        texel_green;
        logic [7:0]        texel_blue;
        logic signed [23:0] coord_u;
        logic signed [23:0] coord_v;
        logic [1:0]        filter_mode;
    } req_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } rsp_t;

    // Request sideband that travels beside the coordinate units
    typedef struct packed {
        logic               write;
        logic               bilinear;
        logic [7:0]         texel_x;
        logic [7:0]         texel_y;
        logic [TEXEL_W-1:0] texel;
    } side_t;

    typedef struct packed {
        logic write;
        logic bilinear;
    } op_ctl_t;

    // Tag that comes back with each texel read
    typedef struct packed {
        logic            valid;
        logic            first;
        logic            last;
        logic [WT_W-1:0] weight;
    } rd_tag_t;

endpackage

// ===== design/texture_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_sampler
// Bilinear / nearest texture sampler over an RGB888 texel memory.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_ready: a write request stores one texel at
// (texel_x, texel_y), a sample request answers one RGB response on
// rsp_valid/rsp_ready. Writes and samples take effect strictly in order.
// tex_width / tex_height are set through cfg_valid/cfg_index/cfg_data; the
// user must do so only while no request is in progress; the block does
// not enforce it, and cfg_ready is always high. Throughput: a write or
// nearest sample every cycle while no bilinear sample holds the memory port
// and, for a sample, the response buffer has room; a bilinear sample makes
// its four texel reads one by one through the single memory port.
// A four-entry response buffer absorbs receiver stalls; the sequencer holds
// back new sample reads when it fills, and the request side then backs up.
// Reset clears control state and sets both size registers to 256. The texel
// memory is not cleared; a texel must be written before it is sampled.
// ----------------------------------------------------------------------------
module texture_sampler #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  ts_pkg::req_t              req_data,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output ts_pkg::rsp_t              rsp_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [ts_pkg::CFG_W-1:0]  cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int SWX   = $clog2(MAX_WIDTH + 1);
    localparam int SWY   = $clog2(MAX_HEIGHT + 1);
    localparam logic [AW-1:0] ROW_LEN = AW'(MAX_HEIGHT);

    logic [ts_pkg::CFG_W-1:0] tex_width_reg;
    logic [ts_pkg::CFG_W-1:0] tex_height_reg;
    logic [SWX-1:0]           size_x;
    logic [SWY-1:0]           size_y;

    logic         s1_valid_reg;
    ts_pkg::req_t s1_req_reg;
    logic         s2_valid_reg;
    ts_pkg::side_t s2_side_reg;
    logic         s3_valid_reg;
    ts_pkg::side_t s3_side_reg;
    logic         s4_valid_reg;
    logic         s4_valid_next;

    ts_pkg::op_ctl_t                            s4_ctl_reg;
    ts_pkg::op_ctl_t                            s4_ctl_next;
    logic [ts_pkg::TAPS-1:0][AW-1:0]            s4_addr_reg;
    logic [ts_pkg::TAPS-1:0][AW-1:0]            s4_addr_next;
    logic [ts_pkg::TAPS-1:0][ts_pkg::WT_W-1:0]  s4_wt_reg;
    logic [ts_pkg::TAPS-1:0][ts_pkg::WT_W-1:0]  s4_wt_next;
    logic [ts_pkg::TEXEL_W-1:0]                 s4_wdata_reg;

    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic op_ready;

    ts_pkg::side_t s1_side;

    logic [XW-1:0] x_lo;
    logic [XW-1:0] x_hi;
    logic [7:0]    wu;
    logic [YW-1:0] y_lo;
    logic [YW-1:0] y_hi;
    logic [7:0]    wv;
    logic [8:0]    iu;
    logic [8:0]    iv;
    logic          in_range;

    logic                       smp_room;
    logic                       smp_start;
    ts_pkg::rd_tag_t            rd_tag;
    logic [ts_pkg::TEXEL_W-1:0] rd_data;

    function automatic logic [AW-1:0] row_addr(input logic [XW-1:0] x,
                                               input logic [YW-1:0] y);
        return AW'(x) * ROW_LEN + AW'(y);
    endfunction

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg  <= 9'd256;
            tex_height_reg <= 9'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ts_pkg::CFG_TEX_WIDTH:  tex_width_reg  <= cfg_data;
                ts_pkg::CFG_TEX_HEIGHT: tex_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Zero reads as one, anything above the maximum saturates
    always_comb
    begin
        if (tex_width_reg == '0)
            size_x = SWX'(1);
        else if (32'(tex_width_reg) > MAX_WIDTH)
            size_x = SWX'(MAX_WIDTH);
        else
            size_x = SWX'(tex_width_reg);
        if (tex_height_reg == '0)
            size_y = SWY'(1);
        else if (32'(tex_height_reg) > MAX_HEIGHT)
            size_y = SWY'(MAX_HEIGHT);
        else
            size_y = SWY'(tex_height_reg);
    end

    // Pipeline advance: a stage loads when it is empty or its successor moves
    assign en4       = !s4_valid_reg || op_ready;
    assign en3       = !s3_valid_reg || en4;
    assign en2       = !s2_valid_reg || en3;
    assign en1       = !s1_valid_reg || en2;
    assign req_ready = en1;

    always_comb
    begin
        s1_side.write    = (s1_req_reg.action == ts_pkg::ACT_WRITE);
        s1_side.bilinear = !(s1_req_reg.filter_mode == ts_pkg::MODE_WRAP ||
                             s1_req_reg.filter_mode == ts_pkg::MODE_CLAMP);
        s1_side.texel_x  = s1_req_reg.texel_x;
        s1_side.texel_y  = s1_req_reg.texel_y;
        s1_side.texel    = {s1_req_reg.texel_red, s1_req_reg.texel_green,
                            s1_req_reg.texel_blue};
    end

    ts_axis #(
        .MAX_SIZE (MAX_WIDTH)
    ) u_axis_x (
        .clk   (clk),
        .en_a  (en2),
        .en_b  (en3),
        .coord (s1_req_reg.coord_u),
        .mode  (s1_req_reg.filter_mode),
        .size  (size_x),
        .lo    (x_lo),
        .hi    (x_hi),
        .wt    (wu)
    );

    ts_axis #(
        .MAX_SIZE (MAX_HEIGHT)
    ) u_axis_y (
        .clk   (clk),
        .en_a  (en2),
        .en_b  (en3),
        .coord (s1_req_reg.coord_v),
        .mode  (s1_req_reg.filter_mode),
        .size  (size_y),
        .lo    (y_lo),
        .hi    (y_hi),
        .wt    (wv)
    );

    // Addresses and blend weights of the four neighbors
    always_comb
    begin
        iu       = 9'd256 - 9'(wu);
        iv       = 9'd256 - 9'(wv);
        in_range = (32'(s3_side_reg.texel_x) < MAX_WIDTH) &&
                   (32'(s3_side_reg.texel_y) < MAX_HEIGHT);
        s4_ctl_next.write    = s3_side_reg.write;
        s4_ctl_next.bilinear = s3_side_reg.bilinear;
        s4_valid_next        = s3_valid_reg && (!s3_side_reg.write || in_range);
        if (s3_side_reg.write)
        begin
            s4_addr_next[0] = row_addr(XW'(s3_side_reg.texel_x), YW'(s3_side_reg.texel_y));
            s4_addr_next[1] = s4_addr_next[0];
            s4_addr_next[2] = s4_addr_next[0];
            s4_addr_next[3] = s4_addr_next[0];
        end
        else
        begin
            s4_addr_next[0] = row_addr(x_lo, y_lo);
            s4_addr_next[1] = row_addr(x_hi, y_lo);
            s4_addr_next[2] = row_addr(x_lo, y_hi);
            s4_addr_next[3] = row_addr(x_hi, y_hi);
        end
        if (s3_side_reg.bilinear)
        begin
            s4_wt_next[0] = ts_pkg::WT_W'(18'(iu) * 18'(iv));
            s4_wt_next[1] = ts_pkg::WT_W'(18'(wu) * 18'(iv));
            s4_wt_next[2] = ts_pkg::WT_W'(18'(iu) * 18'(wv));
            s4_wt_next[3] = ts_pkg::WT_W'(18'(wu) * 18'(wv));
        end
        else
        begin
            s4_wt_next[0] = ts_pkg::WEIGHT_ONE;
            s4_wt_next[1] = '0;
            s4_wt_next[2] = '0;
            s4_wt_next[3] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= req_valid;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                s3_valid_reg <= s2_valid_reg;
            if (en4)
                s4_valid_reg <= s4_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
            s1_req_reg <= req_data;
        if (en2)
            s2_side_reg <= s1_side;
        if (en3)
            s3_side_reg <= s2_side_reg;
        if (en4)
        begin
            s4_ctl_reg   <= s4_ctl_next;
            s4_addr_reg  <= s4_addr_next;
            s4_wt_reg    <= s4_wt_next;
            s4_wdata_reg <= s3_side_reg.texel;
        end
    end

    ts_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (s4_valid_reg),
        .op_ready (op_ready),
        .op_ctl   (s4_ctl_reg),
        .op_addr  (s4_addr_reg),
        .op_wt    (s4_wt_reg),
        .op_wdata (s4_wdata_reg),
        .room     (smp_room),
        .start    (smp_start),
        .tag      (rd_tag),
        .rdata    (rd_data)
    );

    ts_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (smp_start),
        .tag       (rd_tag),
        .rdata     (rd_data),
        .room      (smp_room),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

`ifndef ASSERT_OFF
    a_req_enters: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> s1_valid_reg)
        else $error("accepted request did not enter the pipeline");

    a_op_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg && !op_ready |=> s4_valid_reg && $stable(s4_addr_reg))
        else $error("memory operation changed while waiting for the sequencer");

    a_first_read: assert property (@(posedge clk) disable iff (!rst_n)
        rd_tag.valid && rd_tag.first |-> $past(smp_start))
        else $error("first texel of a sample returned without a sample start");
`endif

endmodule

// ===== design/ts_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_axis
// Two-stage coordinate unit for one axis: scale by the texture size, then
// derive the low and high texel index and the 8-bit blend weight.
// ----------------------------------------------------------------------------
module ts_axis #(
    parameter int MAX_SIZE = 256
) (
    input  logic                               clk,
    input  logic                               en_a,
    input  logic                               en_b,
    input  logic signed [23:0]                 coord,
    input  logic [1:0]                         mode,
    input  logic [$clog2(MAX_SIZE+1)-1:0]      size,
    output logic [$clog2(MAX_SIZE)-1:0]        lo,
    output logic [$clog2(MAX_SIZE)-1:0]        hi,
    output logic [7:0]                         wt
);

    localparam int SW = $clog2(MAX_SIZE + 1);
    localparam int IW = $clog2(MAX_SIZE);
    localparam int PW = 23 + SW;
    localparam int EW = PW - 16;

    logic          neg;
    logic          over;
    logic [22:0]   mag;
    logic [22:0]   opa;
    logic [SW-1:0] opb;

    logic [PW-1:0] prod_reg;
    logic [1:0]    mode_reg;
    logic          neg_reg;

    logic [EW-1:0] whole;
    logic [15:0]   frac;
    logic [EW-1:0] last_idx;
    logic [EW-1:0] a_cl;
    logic [EW-1:0] b_raw;
    logic [EW-1:0] b_cl;
    logic [IW-1:0] lo_next;
    logic [IW-1:0] hi_next;
    logic [7:0]    wt_next;

    logic [IW-1:0] lo_reg;
    logic [IW-1:0] hi_reg;
    logic [7:0]    wt_reg;

    // Stage a: fold or clamp the coordinate and pick the multiplier operands
    always_comb
    begin
        neg  = coord[23];
        mag  = coord[22:0];
        over = !neg && (mag > ts_pkg::Q_ONE);
        opb  = size;
        case (mode)
            ts_pkg::MODE_WRAP:
            begin
                opb = size - SW'(1);
                if (!neg && !over)
                    opa = mag;
                else if (neg && coord[15:0] == 16'd0)
                    opa = ts_pkg::Q_ONE;
                else
                    opa = {7'd0, coord[15:0]};
            end
            ts_pkg::MODE_CLAMP:
                opa = mag;
            default:
                opa = neg ? 23'd0 : (over ? ts_pkg::Q_ONE : mag);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            prod_reg <= PW'(opa) * PW'(opb);
            mode_reg <= mode;
            neg_reg  <= neg;
        end
    end

    // Stage b: integer part, neighbors and weight
    always_comb
    begin
        whole    = prod_reg[PW-1:16];
        frac     = prod_reg[15:0];
        last_idx = EW'(size) - EW'(1);
        a_cl     = (whole > last_idx) ? last_idx : whole;
        b_raw    = whole + EW'(frac != 16'd0);
        b_cl     = (b_raw > last_idx) ? last_idx : b_raw;
        case (mode_reg)
            ts_pkg::MODE_WRAP:
            begin
                lo_next = IW'(whole);
                hi_next = IW'(whole);
                wt_next = 8'd0;
            end
            ts_pkg::MODE_CLAMP:
            begin
                lo_next = neg_reg ? '0 : IW'(a_cl);
                hi_next = lo_next;
                wt_next = 8'd0;
            end
            default:
            begin
                lo_next = IW'(a_cl);
                hi_next = IW'(b_cl);
                wt_next = (a_cl != b_cl) ? frac[15:8] : 8'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            wt_reg <= wt_next;
        end
    end

    assign lo = lo_reg;
    assign hi = hi_reg;
    assign wt = wt_reg;

endmodule

// ===== design/ts_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_store
// Texel memory and sequencer: one access per cycle while no sample waits for
// result room, a write or one read of a sample, each read with its blend tag.
// ----------------------------------------------------------------------------
module ts_store #(
    parameter int DEPTH = 65536
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        op_valid,
    output logic                                        op_ready,
    input  ts_pkg::op_ctl_t                             op_ctl,
    input  logic [ts_pkg::TAPS-1:0][$clog2(DEPTH)-1:0] op_addr,
    input  logic [ts_pkg::TAPS-1:0][ts_pkg::WT_W-1:0]  op_wt,
    input  logic [ts_pkg::TEXEL_W-1:0]                  op_wdata,
    input  logic                                        room,
    output logic                                        start,
    output ts_pkg::rd_tag_t                             tag,
    output logic [ts_pkg::TEXEL_W-1:0]                  rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [ts_pkg::TAP_W-1:0] LAST_TAP = ts_pkg::TAP_W'(ts_pkg::TAPS - 1);

    logic [ts_pkg::TEXEL_W-1:0] texel_mem [DEPTH];

    logic                                        busy_reg;
    ts_pkg::op_ctl_t                             ctl_reg;
    logic [ts_pkg::TAP_W-1:0]                    cnt_reg;
    logic [ts_pkg::TAPS-1:0][AW-1:0]             addr_reg;
    logic [ts_pkg::TAPS-1:0][ts_pkg::WT_W-1:0]   wt_reg;
    logic [ts_pkg::TEXEL_W-1:0]                  wdata_reg;
    ts_pkg::rd_tag_t                             tag_reg;
    logic [ts_pkg::TEXEL_W-1:0]                  rdata_reg;

    logic issue;
    logic last_acc;

    // A sample waits for result room before its first read
    always_comb
    begin
        issue = busy_reg && (ctl_reg.write || cnt_reg != '0 || room);
        start = busy_reg && !ctl_reg.write && cnt_reg == '0 && room;
        if (ctl_reg.write)
            last_acc = 1'b1;
        else if (ctl_reg.bilinear)
            last_acc = (cnt_reg == LAST_TAP);
        else
            last_acc = (cnt_reg == '0);
        op_ready = !busy_reg || (issue && last_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ctl_reg  <= '0;
            cnt_reg  <= '0;
            tag_reg  <= '0;
        end
        else
        begin
            if (op_valid && op_ready)
            begin
                busy_reg <= 1'b1;
                ctl_reg  <= op_ctl;
                cnt_reg  <= '0;
            end
            else if (issue && last_acc)
                busy_reg <= 1'b0;
            else if (issue)
                cnt_reg <= cnt_reg + ts_pkg::TAP_W'(1);

            tag_reg.valid  <= issue && !ctl_reg.write;
            tag_reg.first  <= (cnt_reg == '0);
            tag_reg.last   <= last_acc;
            tag_reg.weight <= wt_reg[cnt_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_valid && op_ready)
        begin
            addr_reg  <= op_addr;
            wt_reg    <= op_wt;
            wdata_reg <= op_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue && ctl_reg.write)
            texel_mem[addr_reg[0]] <= wdata_reg;
        if (issue && !ctl_reg.write)
            rdata_reg <= texel_mem[addr_reg[cnt_reg]];
    end

    assign tag   = tag_reg;
    assign rdata = rdata_reg;

endmodule

// ===== design/ts_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_blend
// Weighted accumulation of returned texels, rounding, and the result buffer
// that decouples the sampler from a stalled receiver.
// ----------------------------------------------------------------------------
module ts_blend (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  ts_pkg::rd_tag_t             tag,
    input  logic [ts_pkg::TEXEL_W-1:0]  rdata,
    output logic                        room,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output ts_pkg::rsp_t                rsp_data
);

    localparam int PTR_W = $clog2(ts_pkg::OUT_DEPTH);
    localparam int CNT_W = $clog2(ts_pkg::OUT_DEPTH + 1);

    logic [2:0][23:0] acc_reg;
    logic [2:0][23:0] acc_next;
    logic [2:0][23:0] rnd;
    logic             done_reg;

    ts_pkg::rsp_t     fifo_mem [ts_pkg::OUT_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] pending_reg;
    logic             pop;
    logic [CNT_W:0]   used;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            acc_next[c] = (tag.first ? 24'd0 : acc_reg[c])
                        + 24'(25'(tag.weight) * 25'(rdata[8*(2-c) +: 8]));
            rnd[c] = acc_reg[c] + ts_pkg::ROUND_HALF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag.valid)
            acc_reg <= acc_next;
        if (done_reg)
            fifo_mem[wr_ptr_reg] <= '{out_red: rnd[0][23:16], out_green: rnd[1][23:16],
                                      out_blue: rnd[2][23:16]};
    end

    assign pop  = rsp_valid && rsp_ready;
    assign used = (CNT_W+1)'(count_reg) + (CNT_W+1)'(pending_reg);
    assign room = used < (CNT_W+1)'(ts_pkg::OUT_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg    <= 1'b0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
            pending_reg <= '0;
        end
        else
        begin
            done_reg <= tag.valid && tag.last;
            if (done_reg)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg   <= count_reg + CNT_W'(done_reg) - CNT_W'(pop);
            pending_reg <= pending_reg + CNT_W'(start) - CNT_W'(done_reg);
        end
    end

    assign rsp_valid = (count_reg != '0);
    assign rsp_data  = fifo_mem[rd_ptr_reg];

endmodule

// ===== tb/sv/texture_sampler_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_sampler_checker
// Watches the request, response and configuration channels of the texture
// sampler, predicts the color of every sample request from its own texel
// store and size registers, and compares each response field by field.
// ----------------------------------------------------------------------------
module texture_sampler_checker #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    input  logic                       req_ready,
    input  ts_pkg::req_t               req_data,
    input  logic                       rsp_valid,
    input  logic                       rsp_ready,
    input  ts_pkg::rsp_t               rsp_data,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [ts_pkg::CFG_W-1:0]   cfg_data,
    output int unsigned                pending,
    output int unsigned                failures
);

    localparam longint UNIT = longint'(ts_pkg::Q_ONE);

    logic [ts_pkg::TEXEL_W-1:0] texels [MAX_WIDTH*MAX_HEIGHT];
    logic [ts_pkg::CFG_W-1:0]   width_raw  = 9'd256;
    logic [ts_pkg::CFG_W-1:0]   height_raw = 9'd256;
    ts_pkg::rsp_t               expected_colors [$];
    int unsigned                fail_count = 0;

    function automatic int usable_span(logic [ts_pkg::CFG_W-1:0] raw, int limit);
        if (raw == 0)
            return 1;
        if (raw > limit)
            return limit;
        return int'(raw);
    endfunction

    function automatic logic [ts_pkg::TEXEL_W-1:0] fetch(int x, int y);
        return texels[x * MAX_HEIGHT + y];
    endfunction

    // Fold into [0,1]; a negative coordinate moves up by whole units
    function automatic longint fold_wrap(longint c);
        if (c >= 0 && c <= UNIT)
            return c;
        if (c > UNIT)
            return c % UNIT;
        return ((UNIT - c) >>> 16) * UNIT + c;
    endfunction

    function automatic int wrap_pick(longint c, int span);
        return int'((fold_wrap(c) * (span - 1)) >>> 16);
    endfunction

    function automatic int clamp_pick(longint c, int span);
        longint p;
        if (c < 0)
            return 0;
        p = (c * span) >>> 16;
        return (p > span - 1) ? span - 1 : int'(p);
    endfunction

    function automatic void blend_axis(input longint c, input int span,
                                       output int lo, output int hi, output int wt);
        longint cc, p, frac, whole, up;
        cc = (c < 0) ? 0 : ((c > UNIT) ? UNIT : c);
        p = cc * span;
        frac = p % UNIT;
        whole = p >>> 16;
        up = whole + ((frac != 0) ? 1 : 0);
        if (whole > span - 1)
            whole = span - 1;
        if (up > span - 1)
            up = span - 1;
        lo = int'(whole);
        hi = int'(up);
        // equal neighbors: one texel carries the full weight
        wt = (whole != up) ? int'(frac >>> 8) : 0;
    endfunction

    function automatic logic [7:0] weigh_channel(int wu, int wv, logic [7:0] c00,
                                                 logic [7:0] c10, logic [7:0] c01,
                                                 logic [7:0] c11);
        longint acc;
        acc = longint'(256 - wu) * (256 - wv) * longint'(c00)
            + longint'(wu) * (256 - wv) * longint'(c10)
            + longint'(256 - wu) * wv * longint'(c01)
            + longint'(wu) * wv * longint'(c11);
        acc = (acc + 32768) >>> 16;
        return acc[7:0];
    endfunction

    function automatic ts_pkg::rsp_t predict_color(ts_pkg::req_t r);
        int           w, h, x0, x1, y0, y1, wu, wv;
        longint       u, v;
        logic [23:0]  q00, q10, q01, q11;
        ts_pkg::rsp_t res;
        w = usable_span(width_raw, MAX_WIDTH);
        h = usable_span(height_raw, MAX_HEIGHT);
        u = {{40{r.coord_u[23]}}, r.coord_u};
        v = {{40{r.coord_v[23]}}, r.coord_v};
        if (r.filter_mode == ts_pkg::MODE_WRAP)
        begin
            res = fetch(wrap_pick(u, w), wrap_pick(v, h));
        end
        else if (r.filter_mode == ts_pkg::MODE_CLAMP)
        begin
            res = fetch(clamp_pick(u, w), clamp_pick(v, h));
        end
        else
        begin
            // the spare mode code lands here as well
            blend_axis(u, w, x0, x1, wu);
            blend_axis(v, h, y0, y1, wv);
            q00 = fetch(x0, y0);
            q10 = fetch(x1, y0);
            q01 = fetch(x0, y1);
            q11 = fetch(x1, y1);
            res.out_red   = weigh_channel(wu, wv, q00[23:16], q10[23:16],
                                          q01[23:16], q11[23:16]);
            res.out_green = weigh_channel(wu, wv, q00[15:8], q10[15:8],
                                          q01[15:8], q11[15:8]);
            res.out_blue  = weigh_channel(wu, wv, q00[7:0], q10[7:0],
                                          q01[7:0], q11[7:0]);
        end
        return res;
    endfunction

    function automatic void check_channel(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ts_pkg::rsp_t want;
        if (!rst_n)
        begin
            width_raw  = 9'd256;
            height_raw = 9'd256;
            expected_colors.delete();
            pending  <= 0;
            failures <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == ts_pkg::CFG_TEX_WIDTH)
                    width_raw = cfg_data;
                else
                    height_raw = cfg_data;
            end
            if (rsp_valid && rsp_ready)
            begin
                if (expected_colors.size() == 0)
                begin
                    $display("%0t: response with nothing expected, expected none, actual %h",
                             $time, rsp_data);
                    fail_count++;
                end
                else
                begin
                    want = expected_colors.pop_front();
                    check_channel("red", want.out_red, rsp_data.out_red);
                    check_channel("green", want.out_green, rsp_data.out_green);
                    check_channel("blue", want.out_blue, rsp_data.out_blue);
                end
            end
            if (req_valid && req_ready)
            begin
                if (req_data.action == ts_pkg::ACT_WRITE)
                    texels[int'(req_data.texel_x) * MAX_HEIGHT + int'(req_data.texel_y)] =
                        {req_data.texel_red, req_data.texel_green, req_data.texel_blue};
                else
                    expected_colors.push_back(predict_color(req_data));
            end
            pending  <= expected_colors.size();
            failures <= fail_count;
        end
    end

endmodule

// ===== tb/sv/texture_sampler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_sampler_tb
// Drives texel writes and sample requests through several texture sizes,
// including saturated 256-texel rows and columns and zero size registers,
// with random idling on both sides and long response stalls; the checker
// beside the block predicts every color.
// ----------------------------------------------------------------------------
module texture_sampler_tb;

    localparam int         RESET_CYCLES   = 7;
    // leave margin after the last request
    localparam int         SETTLE_CYCLES  = 16;
    localparam int         LONG_HOLD      = 96;
    // longest correct quiet stretch is a long hold plus a settle pause
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam logic [1:0] MODE_SPARE     = 2'd3;
    localparam int         DIR_U [8] = '{0, 65536, 32768, -16384, -65536, -8388608,
                                         65535, -1};
    localparam int         DIR_V [8] = '{0, 65536, 16384, 98304, 131072, 8388607,
                                         1, 65537};

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       req_valid = 1'b0;
    logic                       req_ready;
    ts_pkg::req_t               req_data  = '0;
    logic                       rsp_valid;
    logic                       rsp_ready = 1'b0;
    ts_pkg::rsp_t               rsp_data;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic                       cfg_index = ts_pkg::CFG_TEX_WIDTH;
    logic [ts_pkg::CFG_W-1:0]   cfg_data  = '0;

    int unsigned        in_flight;
    int unsigned        mismatches;
    int unsigned        quiet_cycles = 0;
    int unsigned        items_sent   = 0;
    int unsigned        writes_sent  = 0;
    int unsigned        samples_sent [4] = '{0, 0, 0, 0};
    int unsigned        sizes_run    = 0;
    int unsigned        rsp_taken    = 0;
    bit                 texel_written [65536];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    texture_sampler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    texture_sampler_checker u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (in_flight),
        .failures  (mismatches)
    );

    function automatic ts_pkg::req_t noisy_item();
        logic [95:0] noise;
        noise = {$urandom(), $urandom(), $urandom()};
        return noise[$bits(ts_pkg::req_t)-1:0];
    endfunction

    function automatic logic signed [23:0] pick_coord(int span);
        int c;
        case ($urandom_range(0, 9))
            0, 1, 2: c = $urandom_range(0, 65536);
            3:       c = int'(($urandom_range(0, span) * 65536) / span);
            4:       c = int'($urandom_range(0, 262144)) - 131072;
            5:       c = -int'($urandom_range(1, 65535));
            6:       c = (int'($urandom_range(0, 255)) - 128) * 65536;
            7:
            begin
                case ($urandom_range(0, 5))
                    0:       c = -8388608;
                    1:       c = 8388607;
                    2:       c = 65535;
                    3:       c = 65537;
                    4:       c = -1;
                    default: c = 1;
                endcase
            end
            default: c = int'($urandom());
        endcase
        return c[23:0];
    endfunction

    function automatic ts_pkg::req_t random_item(int fw, int fh);
        ts_pkg::req_t r;
        r = noisy_item();
        if ($urandom_range(0, 9) < 3)
        begin
            r.action = ts_pkg::ACT_WRITE;
            // mostly rewrite texels in use, sometimes anywhere in the store
            if ($urandom_range(0, 9) < 7)
            begin
                r.texel_x = 8'($urandom_range(0, fw - 1));
                r.texel_y = 8'($urandom_range(0, fh - 1));
            end
        end
        else
        begin
            r.action  = ts_pkg::ACT_SAMPLE;
            r.coord_u = pick_coord(fw);
            r.coord_v = pick_coord(fh);
            case ($urandom_range(0, 19))
                0:                r.filter_mode = MODE_SPARE;
                1, 2, 3, 4, 5, 6: r.filter_mode = ts_pkg::MODE_WRAP;
                7, 8, 9, 10, 11:  r.filter_mode = ts_pkg::MODE_CLAMP;
                default:          r.filter_mode = ts_pkg::MODE_BILINEAR;
            endcase
        end
        return r;
    endfunction

    task automatic send_req(input ts_pkg::req_t r);
        int unsigned gap;
        gap = (((items_sent / 40) % 3) == 2) ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_data  <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        items_sent++;
        if (r.action == ts_pkg::ACT_WRITE)
        begin
            texel_written[{r.texel_x, r.texel_y}] = 1'b1;
            writes_sent++;
        end
        else
        begin
            samples_sent[r.filter_mode]++;
        end
    endtask

    // Hold requests until every sample has answered, then let writes land
    task automatic drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (in_flight != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_size(input logic [ts_pkg::CFG_W-1:0] w,
                            input logic [ts_pkg::CFG_W-1:0] h);
        cfg_index <= ts_pkg::CFG_TEX_WIDTH;
        cfg_data  <= w;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= ts_pkg::CFG_TEX_HEIGHT;
        cfg_data  <= h;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sizes_run++;
    endtask

    task automatic run_phase(input logic [ts_pkg::CFG_W-1:0] raw_w,
                             input logic [ts_pkg::CFG_W-1:0] raw_h,
                             input int fw, input int fh, input int count, input bit directed);
        ts_pkg::req_t r;
        int           u, v;
        drain();
        set_size(raw_w, raw_h);
        // write every texel the new size can reach before sampling it
        for (int x = 0; x < fw; x++)
        begin
            for (int y = 0; y < fh; y++)
            begin
                if (!texel_written[{x[7:0], y[7:0]}])
                begin
                    r = noisy_item();
                    r.action  = ts_pkg::ACT_WRITE;
                    r.texel_x = x[7:0];
                    r.texel_y = y[7:0];
                    if (directed)
                        {r.texel_red, r.texel_green, r.texel_blue} =
                            ((x + y) % 2 == 1) ? 24'hFFFFFF : 24'h000000;
                    send_req(r);
                end
            end
        end
        if (directed)
        begin
            for (int k = 0; k < 8; k++)
            begin
                u = DIR_U[k];
                v = DIR_V[k];
                r = noisy_item();
                r.action  = ts_pkg::ACT_SAMPLE;
                r.coord_u = u[23:0];
                r.coord_v = v[23:0];
                r.filter_mode = ts_pkg::MODE_WRAP;
                send_req(r);
                r.filter_mode = ts_pkg::MODE_CLAMP;
                send_req(r);
                r.filter_mode = ts_pkg::MODE_BILINEAR;
                send_req(r);
            end
            r.coord_u = 24'sd21845;
            r.coord_v = 24'sd43690;
            r.filter_mode = MODE_SPARE;
            send_req(r);
        end
        for (int n = 0; n < count; n++)
            send_req(random_item(fw, fh));
    endtask

    // Response side: random pauses, calm stretches, and two long holds
    initial
    begin
        int unsigned pause;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rsp_taken == 8 || rsp_taken == 45)
                pause = LONG_HOLD;
            else if (((rsp_taken / 30) % 3) == 1)
                pause = 0;
            else
                pause = $urandom_range(0, 3);
            if (pause > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
            rsp_taken++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("texture_sampler verification failed");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        run_phase(9'd4,   9'd3,   4,   3,   35,  1'b1);
        // oversized width saturates at the store size, zero height acts as one
        run_phase(9'd300, 9'd0,   256, 1,   20,  1'b0);
        // zero width acts as one, oversized height saturates
        run_phase(9'd0,   9'd511, 1,   256, 20,  1'b0);
        run_phase(9'd7,   9'd5,   7,   5,   15,  1'b0);
        run_phase(9'd2,   9'd2,   2,   2,   15,  1'b0);
        drain();
        $display("Sent %0d texel writes and %0d samples: wrap %0d, clamp %0d, bilinear %0d,",
                 writes_sent, samples_sent[0] + samples_sent[1] + samples_sent[2] +
                 samples_sent[3], samples_sent[ts_pkg::MODE_WRAP],
                 samples_sent[ts_pkg::MODE_CLAMP], samples_sent[ts_pkg::MODE_BILINEAR]);
        $display("  spare code %0d, over %0d texture sizes with long response stalls",
                 samples_sent[MODE_SPARE], sizes_run);
        if (mismatches == 0)
            $display("texture_sampler verification clean");
        else
            $display("texture_sampler verification failed");
        $finish;
    end

endmodule
